// File: hw/rtl/ugls_pkg.sv
// ----------------------------------------------------------------------------
// ugls_pkg
// Shared types and constants for the UTC/GPS leap-second converter.
// ----------------------------------------------------------------------------
package ugls_pkg;

  localparam int unsigned CNT_W   = 6;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned UTC_W   = 32;
  localparam int unsigned GPS_W   = 33;
  localparam int unsigned USEC_W  = 20;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  // 3657 days plus 9 s between the Unix and GPS epochs
  localparam logic [GPS_W-1:0]  PRE_OFFSET   = 33'd315964809;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_UTC2GPS = 2'd1,
    OP_GPS2UTC = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACC_NORMAL = 2'd0,
    ACC_LEAP   = 2'd1,
    ACC_PRE    = 2'd2,
    ACC_WRITE  = 2'd3
  } acc_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic wr_en;
    logic scan;
    logic calc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/ugls_ctrl.sv
// ----------------------------------------------------------------------------
// ugls_ctrl
// Sequencer for table writes, table scans and result hand-off.
// ----------------------------------------------------------------------------
module ugls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ugls_pkg::op_e     op_i,
  input  ugls_pkg::status_t status_i,
  output logic              in_ready_o,
  output ugls_pkg::cmd_t    cmd_o
);

  ugls_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ugls_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ugls_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (op_i)
            ugls_pkg::OP_WRITE:   state_d = ugls_pkg::ST_WRITE;
            ugls_pkg::OP_UTC2GPS: state_d = ugls_pkg::ST_SCAN;
            ugls_pkg::OP_GPS2UTC: state_d = ugls_pkg::ST_SCAN;
            default:              state_d = ugls_pkg::ST_IDLE;
          endcase
        end
      end
      ugls_pkg::ST_WRITE: state_d = ugls_pkg::ST_DONE;
      ugls_pkg::ST_SCAN: begin
        if (status_i.hit || status_i.exhausted) begin
          state_d = ugls_pkg::ST_CALC;
        end
      end
      ugls_pkg::ST_CALC: state_d = ugls_pkg::ST_DONE;
      ugls_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ugls_pkg::ST_IDLE;
        end
      end
      default: state_d = ugls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ugls_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ugls_pkg::ST_WRITE: cmd_o.wr_en = 1'b1;
      ugls_pkg::ST_SCAN:  cmd_o.scan  = 1'b1;
      ugls_pkg::ST_CALC:  cmd_o.calc  = 1'b1;
      ugls_pkg::ST_DONE:  cmd_o.emit  = status_i.out_free;
      default: ;
    endcase
  end

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ugls_pkg::ST_SCAN) && (status_i.hit || status_i.exhausted)
      |=> (state_q == ugls_pkg::ST_CALC))
    else $error("scan did not stop on hit or end of table");

  a_write_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ugls_pkg::ST_WRITE) |=> (state_q == ugls_pkg::ST_DONE))
    else $error("write did not proceed to result");

  a_done_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ugls_pkg::ST_DONE) && status_i.out_free
      |=> (state_q == ugls_pkg::ST_IDLE))
    else $error("result hand-off stuck");

endmodule

// File: hw/rtl/ugls_datapath.sv
// ----------------------------------------------------------------------------
// ugls_datapath
// Leap table memories, descending scan compare and time arithmetic.
// ----------------------------------------------------------------------------
module ugls_datapath #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ugls_pkg::cmd_t                  cmd_i,
  output ugls_pkg::status_t               status_o,
  input  logic                            cfg_we_i,
  input  logic [ugls_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  ugls_pkg::op_e                   op_i,
  input  logic [ugls_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [ugls_pkg::UTC_W-1:0]      entry_utc_seconds_i,
  input  logic [ugls_pkg::GPS_W-1:0]      entry_gps_seconds_i,
  input  logic [ugls_pkg::UTC_W-1:0]      utc_seconds_i,
  input  logic [ugls_pkg::USEC_W-1:0]     utc_microseconds_i,
  input  logic [ugls_pkg::GPS_W-1:0]      gps_seconds_i,
  input  logic [ugls_pkg::USEC_W-1:0]     gps_microseconds_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [ugls_pkg::GPS_W-1:0]      result_seconds_o,
  output logic [ugls_pkg::USEC_W-1:0]     result_microseconds_o,
  output ugls_pkg::acc_e                  accuracy_o
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = ugls_pkg::CNT_W;
  localparam int unsigned UW = ugls_pkg::UTC_W;
  localparam int unsigned GW = ugls_pkg::GPS_W;
  localparam int unsigned SW = ugls_pkg::USEC_W;

  logic [UW-1:0] mem_utc [MAX_ENTRIES];
  logic [GW-1:0] mem_gps [MAX_ENTRIES];

  logic [CW-1:0] cnt_q;
  logic [CW-1:0] active_n;
  logic [CW-1:0] remain_q, remain_d;
  logic          rvalid_q, rvalid_d;
  logic          issue;
  logic [CW-1:0] remain_m1;
  logic [AW-1:0] rd_addr;
  logic [UW-1:0] rd_utc_q;
  logic [GW-1:0] rd_gps_q;

  ugls_pkg::op_e op_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_ok_q;
  logic [UW-1:0] wr_utc_q;
  logic [GW-1:0] wr_gps_q;
  logic [GW-1:0] ut_q;      // unsigned, one bit of headroom for the carry
  logic [GW:0]   gs_q;      // signed, one bit of headroom for the carry
  logic [SW-1:0] usec_q;

  logic [SW-1:0] in_us;
  logic          us_carry;

  logic          found_q;
  logic [UW-1:0] sel_utc_q;
  logic [GW-1:0] sel_gps_q;

  logic          utc_le, gps_le, match;
  logic          in_leap;
  logic [GW-1:0] calc_sec_d, calc_sec_q;
  ugls_pkg::acc_e calc_acc_d, calc_acc_q;

  logic          out_valid_q;
  logic [GW-1:0] out_sec_q;
  logic [SW-1:0] out_us_q;
  ugls_pkg::acc_e out_acc_q;

  // entry count register; counts beyond the table depth clamp to it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      cnt_q <= cfg_wdata_i;
    end
  end

  assign active_n = (32'(cnt_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : cnt_q;

  // input capture with microsecond carry
  assign in_us    = (op_i == ugls_pkg::OP_UTC2GPS) ? utc_microseconds_i : gps_microseconds_i;
  assign us_carry = (in_us >= ugls_pkg::USEC_PER_SEC);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      wr_addr_q <= AW'(entry_index_i);
      wr_ok_q   <= (32'(entry_index_i) < MAX_ENTRIES);
      wr_utc_q  <= entry_utc_seconds_i;
      wr_gps_q  <= entry_gps_seconds_i;
      usec_q    <= us_carry ? SW'(in_us - ugls_pkg::USEC_PER_SEC) : in_us;
      ut_q      <= {1'b0, utc_seconds_i} + GW'(us_carry);
      gs_q      <= {gps_seconds_i[GW-1], gps_seconds_i} + (GW+1)'(us_carry);
    end
  end

  // scan walks from the top entry downward, one read per cycle
  assign issue     = cmd_i.scan && (remain_q != '0);
  assign remain_m1 = remain_q - CW'(1);
  assign rd_addr   = AW'(remain_m1);

  always_comb begin
    remain_d = remain_q;
    rvalid_d = 1'b0;
    if (cmd_i.load) begin
      remain_d = active_n;
    end else if (issue) begin
      remain_d = remain_m1;
      rvalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      rvalid_q <= 1'b0;
    end else begin
      remain_q <= remain_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok_q) begin
      mem_utc[wr_addr_q] <= wr_utc_q;
      mem_gps[wr_addr_q] <= wr_gps_q;
    end
    if (issue) begin
      rd_utc_q <= mem_utc[rd_addr];
      rd_gps_q <= mem_gps[rd_addr];
    end
  end

  // gps entry marks the second after the leap; the leap starts one earlier
  assign utc_le = ({1'b0, rd_utc_q} <= ut_q);
  assign gps_le = ($signed({{2{rd_gps_q[GW-1]}}, rd_gps_q} - (GW+2)'(1))
                   <= $signed({gs_q[GW], gs_q}));
  assign match  = (op_q == ugls_pkg::OP_UTC2GPS) ? utc_le : gps_le;

  assign status_o.hit       = cmd_i.scan && rvalid_q && match;
  assign status_o.exhausted = (remain_q == '0) && !rvalid_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (status_o.hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (status_o.hit) begin
      sel_utc_q <= rd_utc_q;
      sel_gps_q <= rd_gps_q;
    end
  end

  assign in_leap = ($signed({gs_q[GW], gs_q}) < $signed({sel_gps_q[GW-1], sel_gps_q}));

  always_comb begin
    calc_sec_d = '0;
    calc_acc_d = ugls_pkg::ACC_NORMAL;
    if (op_q == ugls_pkg::OP_UTC2GPS) begin
      if (found_q) begin
        calc_sec_d = GW'(sel_gps_q + ut_q - {1'b0, sel_utc_q});
        calc_acc_d = (ut_q == {1'b0, sel_utc_q}) ? ugls_pkg::ACC_LEAP
                                                  : ugls_pkg::ACC_NORMAL;
      end else begin
        calc_sec_d = GW'(ut_q - ugls_pkg::PRE_OFFSET);
        calc_acc_d = ugls_pkg::ACC_PRE;
      end
    end else begin
      if (found_q) begin
        if (in_leap) begin
          // inside the leap second: map onto the following UTC second
          calc_sec_d = {1'b0, sel_utc_q};
          calc_acc_d = ugls_pkg::ACC_LEAP;
        end else begin
          calc_sec_d = GW'({1'b0, sel_utc_q} + gs_q[GW-1:0] - sel_gps_q);
          calc_acc_d = ugls_pkg::ACC_NORMAL;
        end
      end else begin
        calc_sec_d = GW'(gs_q[GW-1:0] + ugls_pkg::PRE_OFFSET);
        calc_acc_d = ugls_pkg::ACC_PRE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      calc_sec_q <= calc_sec_d;
      calc_acc_q <= calc_acc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (op_q == ugls_pkg::OP_WRITE) begin
        out_sec_q <= '0;
        out_us_q  <= '0;
        out_acc_q <= ugls_pkg::ACC_WRITE;
      end else begin
        out_sec_q <= calc_sec_q;
        out_us_q  <= usec_q;
        out_acc_q <= calc_acc_q;
      end
    end
  end

  assign out_valid_o           = out_valid_q;
  assign result_seconds_o      = out_sec_q;
  assign result_microseconds_o = out_us_q;
  assign accuracy_o            = out_acc_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an untaken transfer");

  a_remain_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(remain_q) <= MAX_ENTRIES)
    else $error("scan pointer beyond table depth");

  a_rvalid_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> $past(cmd_i.scan))
    else $error("read data valid without a scan read");

endmodule

// File: hw/rtl/utc_gps_leap_second_converter_core.sv
// ----------------------------------------------------------------------------
// utc_gps_leap_second_converter_core
// Converts between Unix UTC and GPS time through a loaded leap-second table.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                              Content
// s_axis    in   tvalid/tready/tdata[175:0]/tuser[1:0] table write or time to convert
// m_axis    out  tvalid/tready/tdata[55:0]/tuser[1:0]  converted time and accuracy
// cfg       in   cfg_we_i/cfg_wdata_i[5:0]            number of table entries in use
//
// A table write passes through the WRITE and DONE states before its result
// is registered. A conversion passes through SCAN, CALC and DONE; SCAN reads
// m entries, m being the number of entries read before the match (up to
// entry_count), through the single read port of the table memory, read once
// a cycle from the top entry down. One item is in work at a time; the next
// one is taken while a result waits in the output register. Reset clears the
// entry count and all control; the table contents are undefined until written.
// ----------------------------------------------------------------------------
module utc_gps_leap_second_converter_core #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [5:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // entry_index, entry_utc_seconds, entry_gps_seconds, utc_seconds,
  // utc_microseconds, gps_seconds, gps_microseconds, zero pad
  input  logic [175:0] s_axis_tdata_i,
  // operation
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // result_seconds, result_microseconds, zero pad
  output logic [55:0]  m_axis_tdata_o,
  // accuracy
  output logic [1:0]   m_axis_tuser_o
);

  ugls_pkg::cmd_t    cmd;
  ugls_pkg::status_t status;
  ugls_pkg::op_e     op;
  ugls_pkg::acc_e    accuracy;
  logic [ugls_pkg::GPS_W-1:0]  result_seconds;
  logic [ugls_pkg::USEC_W-1:0] result_microseconds;

  assign op = ugls_pkg::op_e'(s_axis_tuser_i);

  ugls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .op_i       (op),
    .status_i   (status),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  ugls_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .status_o              (status),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .op_i                  (op),
    .entry_index_i         (s_axis_tdata_i[4:0]),
    .entry_utc_seconds_i   (s_axis_tdata_i[36:5]),
    .entry_gps_seconds_i   (s_axis_tdata_i[69:37]),
    .utc_seconds_i         (s_axis_tdata_i[101:70]),
    .utc_microseconds_i    (s_axis_tdata_i[121:102]),
    .gps_seconds_i         (s_axis_tdata_i[154:122]),
    .gps_microseconds_i    (s_axis_tdata_i[174:155]),
    .out_ready_i           (m_axis_tready_i),
    .out_valid_o           (m_axis_tvalid_o),
    .result_seconds_o      (result_seconds),
    .result_microseconds_o (result_microseconds),
    .accuracy_o            (accuracy)
  );

  assign m_axis_tdata_o = {3'b000, result_microseconds, result_seconds};
  assign m_axis_tuser_o = accuracy;

endmodule
